### src/ckpt_pkg.sv
package ckpt_pkg;

  localparam int unsigned EXEC_BITS_DEF = 12;
  localparam int unsigned BUDGET_W      = 24;
  localparam int unsigned EPU_W         = 8;
  localparam int unsigned CCOST_W       = 4;
  localparam int unsigned CPS_W         = 12;
  localparam int unsigned FIN_W         = 17;
  localparam int unsigned ENERGY_W      = 25;
  localparam int unsigned APB_DW        = 32;
  localparam int unsigned APB_AW        = 3;
  localparam int unsigned UPC_W         = 4;

  localparam logic [EPU_W-1:0]   EPU_RESET   = 8'd25;
  localparam logic [CCOST_W-1:0] CCOST_RESET = 4'd1;

  // Register index, taken from byte address bit 2.
  typedef enum logic [0:0] {
    REG_ENERGY_PER_UNIT = 1'b0,
    REG_CHECKPOINT_COST = 1'b1
  } ckpt_reg_e;

  // Jump conditions of the microcode.
  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_DIV_BUSY,
    COND_RISE,
    COND_OVER,
    COND_OUT_FULL
  } ckpt_cond_e;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_COST,
    MUL_PREV
  } ckpt_mul_e;

  typedef struct packed {
    ckpt_cond_e       cond;
    logic [UPC_W-1:0] target;
    logic             accept;
    logic             div_start;
    logic             cost_en;
    ckpt_mul_e        mul;
    logic             advance;
    logic             wr_ok;
    logic             wr_fail;
  } ckpt_ctrl_t;

  typedef struct packed {
    logic no_input;
    logic div_busy;
    logic rise;
    logic over;
    logic out_full;
  } ckpt_flags_t;

endpackage

### src/ckpt_if.sv
interface ckpt_in_if #(
  parameter int unsigned EXEC_BITS = ckpt_pkg::EXEC_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [EXEC_BITS-1:0]          exec_time;
  logic [ckpt_pkg::BUDGET_W-1:0] energy_budget;

  modport source (output valid, exec_time, energy_budget, input ready);
  modport sink (input valid, exec_time, energy_budget, output ready);
endinterface

interface ckpt_out_if;
  logic                          valid;
  logic                          ready;
  logic                          schedulable;
  logic [ckpt_pkg::CPS_W-1:0]    checkpoints;
  logic [ckpt_pkg::FIN_W-1:0]    finish_time;
  logic [ckpt_pkg::ENERGY_W-1:0] energy_needed;

  modport source (output valid, schedulable, checkpoints, finish_time, energy_needed,
                  input ready);
  modport sink (input valid, schedulable, checkpoints, finish_time, energy_needed,
                output ready);
endinterface

### src/ckpt_div.sv
module ckpt_div #(
  parameter int unsigned W = ckpt_pkg::EXEC_BITS_DEF + 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         busy_o,
  output logic [W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem_q, rem_d, quo_q, quo_d, div_q, div_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W:0]       trial, diff;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    trial = {rem_q, quo_q[W-1]};
    diff  = trial - {1'b0, div_q};
    rem_d = rem_q;
    quo_d = quo_q;
    div_d = div_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      div_d = divisor_i;
      cnt_d = CNT_W'(W);
    end else if (cnt_q != '0) begin
      if (!diff[W]) begin
        rem_d = diff[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_o)
    else $error("division started while the previous one runs");

  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> divisor_i != '0)
    else $error("division by zero started");

  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |=> busy_o)
    else $error("divider not busy after start");

endmodule

### src/ckpt_seq.sv
module ckpt_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ckpt_pkg::ckpt_flags_t flags_i,
  output ckpt_pkg::ckpt_ctrl_t  ctrl_o
);

  localparam logic [ckpt_pkg::UPC_W-1:0] S_IDLE    = 4'd0;
  localparam logic [ckpt_pkg::UPC_W-1:0] S_DIV     = 4'd1;
  localparam logic [ckpt_pkg::UPC_W-1:0] S_WAIT    = 4'd2;
  localparam logic [ckpt_pkg::UPC_W-1:0] S_COST    = 4'd3;
  localparam logic [ckpt_pkg::UPC_W-1:0] S_MUL     = 4'd4;
  localparam logic [ckpt_pkg::UPC_W-1:0] S_CMP     = 4'd5;
  localparam logic [ckpt_pkg::UPC_W-1:0] S_CHK     = 4'd6;
  localparam logic [ckpt_pkg::UPC_W-1:0] S_ADV     = 4'd7;
  localparam logic [ckpt_pkg::UPC_W-1:0] S_OK_MUL  = 4'd8;
  localparam logic [ckpt_pkg::UPC_W-1:0] S_OK_WR   = 4'd9;
  localparam logic [ckpt_pkg::UPC_W-1:0] S_OK_RET  = 4'd10;
  localparam logic [ckpt_pkg::UPC_W-1:0] S_FAIL_WR = 4'd11;
  localparam logic [ckpt_pkg::UPC_W-1:0] S_FAIL_RET = 4'd12;

  logic [ckpt_pkg::UPC_W-1:0] upc_q, upc_d;
  logic                       take;

  function automatic ckpt_pkg::ckpt_ctrl_t mk(
    input ckpt_pkg::ckpt_cond_e       cond,
    input logic [ckpt_pkg::UPC_W-1:0] target
  );
    ckpt_pkg::ckpt_ctrl_t w;
    w        = '0;
    w.cond   = cond;
    w.target = target;
    w.mul    = ckpt_pkg::MUL_NONE;
    return w;
  endfunction

  // Microcode store: one control word per step.
  always_comb begin
    ctrl_o = mk(ckpt_pkg::COND_ALWAYS, S_IDLE);
    case (upc_q)
      S_IDLE: begin
        ctrl_o        = mk(ckpt_pkg::COND_NO_INPUT, S_IDLE);
        ctrl_o.accept = 1'b1;
      end
      S_DIV: begin
        ctrl_o           = mk(ckpt_pkg::COND_NONE, S_IDLE);
        ctrl_o.div_start = 1'b1;
      end
      S_WAIT: ctrl_o = mk(ckpt_pkg::COND_DIV_BUSY, S_WAIT);
      S_COST: begin
        ctrl_o         = mk(ckpt_pkg::COND_NONE, S_IDLE);
        ctrl_o.cost_en = 1'b1;
      end
      S_MUL: begin
        ctrl_o     = mk(ckpt_pkg::COND_NONE, S_IDLE);
        ctrl_o.mul = ckpt_pkg::MUL_COST;
      end
      S_CMP: ctrl_o = mk(ckpt_pkg::COND_RISE, S_OK_MUL);
      S_CHK: ctrl_o = mk(ckpt_pkg::COND_OVER, S_FAIL_WR);
      S_ADV: begin
        ctrl_o         = mk(ckpt_pkg::COND_ALWAYS, S_DIV);
        ctrl_o.advance = 1'b1;
      end
      S_OK_MUL: begin
        ctrl_o     = mk(ckpt_pkg::COND_NONE, S_IDLE);
        ctrl_o.mul = ckpt_pkg::MUL_PREV;
      end
      S_OK_WR: begin
        ctrl_o       = mk(ckpt_pkg::COND_OUT_FULL, S_OK_WR);
        ctrl_o.wr_ok = 1'b1;
      end
      S_OK_RET: ctrl_o = mk(ckpt_pkg::COND_ALWAYS, S_IDLE);
      S_FAIL_WR: begin
        ctrl_o         = mk(ckpt_pkg::COND_OUT_FULL, S_FAIL_WR);
        ctrl_o.wr_fail = 1'b1;
      end
      S_FAIL_RET: ctrl_o = mk(ckpt_pkg::COND_ALWAYS, S_IDLE);
      default: ctrl_o = mk(ckpt_pkg::COND_ALWAYS, S_IDLE);
    endcase
  end

  always_comb begin
    case (ctrl_o.cond)
      ckpt_pkg::COND_NONE:     take = 1'b0;
      ckpt_pkg::COND_ALWAYS:   take = 1'b1;
      ckpt_pkg::COND_NO_INPUT: take = flags_i.no_input;
      ckpt_pkg::COND_DIV_BUSY: take = flags_i.div_busy;
      ckpt_pkg::COND_RISE:     take = flags_i.rise;
      ckpt_pkg::COND_OVER:     take = flags_i.over;
      ckpt_pkg::COND_OUT_FULL: take = flags_i.out_full;
      default:                 take = 1'b1;
    endcase
    upc_d = take ? ctrl_o.target : upc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) upc_q <= S_FAIL_RET)
    else $error("step counter left the program");

endmodule

### src/checkpoint_count_search.sv
// Checkpoint count search.
// A task arrives as one transfer on in_ch (execution time and energy budget).
// The block walks n = 1, 2, ... evaluating e + n*r + ceil(e/n), where r is the
// checkpoint_cost register, and stops at the first n whose cost rises above
// the previous one. It then returns one transfer on out_ch: n-1 checkpoints,
// the previous cost as finish time and that cost times energy_per_unit.
// Should a non-final step need more energy than the budget, the result is
// marked not schedulable with all other fields zero.
// Each count examined spends almost all of its time in the restoring divider,
// which yields one quotient bit per cycle. A task examines N counts, and the
// next task can be taken after its result is written. N is near sqrt(e / r) + 1,
// about 66 at most for a 12-bit time with unit overhead.
// One task is worked on at a time.
// The result sits in an output register, so while the receiver stalls the
// next task is taken in and searched; only its final write waits.
// Reset clears the sequencer, the divider count and the output valid flag and
// loads energy_per_unit = 25 and checkpoint_cost = 1. The user must write the
// registers over the APB port at byte addresses 0 and 4 while the block is idle;
// the block does not enforce this. A checkpoint_cost of zero behaves as one.
module checkpoint_count_search #(
  parameter int unsigned EXEC_BITS = ckpt_pkg::EXEC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ckpt_pkg::APB_AW-1:0]   paddr,
  input  logic [ckpt_pkg::APB_DW-1:0]   pwdata,
  output logic [ckpt_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  ckpt_in_if.sink                       in_ch,
  ckpt_out_if.source                    out_ch
);

  // Step count, cost and product widths.
  localparam int unsigned NW   = EXEC_BITS + 1;
  localparam int unsigned CW   = EXEC_BITS + 5;
  localparam int unsigned PW   = CW + ckpt_pkg::EPU_W;
  localparam int unsigned CMPW = (PW > ckpt_pkg::BUDGET_W) ? PW : ckpt_pkg::BUDGET_W;

  ckpt_pkg::ckpt_ctrl_t  ctrl;
  ckpt_pkg::ckpt_flags_t flags;

  // Configuration registers.
  logic [ckpt_pkg::EPU_W-1:0]   cfg_epu_q;
  logic [ckpt_pkg::CCOST_W-1:0] cfg_cost_q;
  logic                         cfg_wr;
  ckpt_pkg::ckpt_reg_e          cfg_idx;

  // Datapath.
  logic [EXEC_BITS-1:0]          e_q;
  logic [ckpt_pkg::BUDGET_W-1:0] budget_q;
  logic [ckpt_pkg::CCOST_W-1:0]  r_q, r_sat;
  logic [ckpt_pkg::EPU_W-1:0]    k_q;
  logic [NW-1:0]                 n_q;
  logic [CW-1:0]                 nr_q, cost_q, prev_q, mul_a;
  logic [PW-1:0]                 prod_q;
  logic                          first_q;
  logic                          in_fire;
  logic [NW-1:0]                 dividend, quotient;
  logic                          div_busy;

  // Output register.
  logic                          out_valid_q, out_valid_d;
  logic                          sched_q;
  logic [ckpt_pkg::CPS_W-1:0]    cps_q;
  logic [ckpt_pkg::FIN_W-1:0]    fin_q;
  logic [ckpt_pkg::ENERGY_W-1:0] en_q;
  logic                          out_full, wr;

  // APB port: writes complete in the access cycle, pready is tied high.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = ckpt_pkg::ckpt_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_epu_q  <= ckpt_pkg::EPU_RESET;
      cfg_cost_q <= ckpt_pkg::CCOST_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ckpt_pkg::REG_ENERGY_PER_UNIT: cfg_epu_q  <= pwdata[ckpt_pkg::EPU_W-1:0];
        ckpt_pkg::REG_CHECKPOINT_COST: cfg_cost_q <= pwdata[ckpt_pkg::CCOST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      ckpt_pkg::REG_ENERGY_PER_UNIT: prdata = ckpt_pkg::APB_DW'(cfg_epu_q);
      ckpt_pkg::REG_CHECKPOINT_COST: prdata = ckpt_pkg::APB_DW'(cfg_cost_q);
      default:                       prdata = '0;
    endcase
  end

  // Sequencer and divider.
  ckpt_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  // ceil(e / n) is computed as (e + n - 1) / n.
  assign dividend = NW'(e_q) + n_q - NW'(1);

  ckpt_div #(
    .W (NW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.div_start),
    .dividend_i (dividend),
    .divisor_i  (n_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  assign in_ch.ready = ctrl.accept;
  assign in_fire     = in_ch.valid && ctrl.accept;
  assign r_sat       = (cfg_cost_q == '0) ? ckpt_pkg::CCOST_W'(1) : cfg_cost_q;
  assign mul_a       = (ctrl.mul == ckpt_pkg::MUL_PREV) ? prev_q : cost_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      e_q      <= in_ch.exec_time;
      budget_q <= in_ch.energy_budget;
      r_q      <= r_sat;
      k_q      <= cfg_epu_q;
      n_q      <= NW'(1);
      nr_q     <= CW'(r_sat);
    end
    if (ctrl.cost_en) begin
      cost_q <= CW'(e_q) + nr_q + CW'(quotient);
    end
    if (ctrl.mul != ckpt_pkg::MUL_NONE) begin
      prod_q <= PW'(mul_a) * PW'(k_q);
    end
    if (ctrl.advance) begin
      prev_q <= cost_q;
      n_q    <= n_q + NW'(1);
      nr_q   <= nr_q + CW'(r_q);
    end
  end

  // The first count has no predecessor to compare against.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (in_fire) begin
      first_q <= 1'b1;
    end else if (ctrl.advance) begin
      first_q <= 1'b0;
    end
  end

  assign out_full       = out_valid_q && !out_ch.ready;
  assign flags.no_input = !in_ch.valid;
  assign flags.div_busy = div_busy;
  assign flags.rise     = !first_q && (cost_q > prev_q);
  assign flags.over     = CMPW'(prod_q) > CMPW'(budget_q);
  assign flags.out_full = out_full;

  // Result write; the sequencer holds the write step while the slot is full.
  assign wr          = (ctrl.wr_ok || ctrl.wr_fail) && !out_full;
  assign out_valid_d = wr ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      sched_q <= ctrl.wr_ok;
      cps_q   <= ctrl.wr_ok ? ckpt_pkg::CPS_W'(n_q - NW'(1)) : '0;
      fin_q   <= ctrl.wr_ok ? ckpt_pkg::FIN_W'(prev_q) : '0;
      en_q    <= ctrl.wr_ok ? ckpt_pkg::ENERGY_W'(prod_q) : '0;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.schedulable   = sched_q;
  assign out_ch.checkpoints   = cps_q;
  assign out_ch.finish_time   = fin_q;
  assign out_ch.energy_needed = en_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> !in_ch.ready)
    else $error("second task taken while a search runs");

  assert property (@(posedge clk_i) disable iff (!rst_ni) in_ch.ready |-> !div_busy)
    else $error("divider still busy while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni) ctrl.wr_ok |-> !first_q)
    else $error("successful result before any count was compared");

endmodule
